// ----- hw/rtl/gdfs_pkg.sv -----
// Shared types, constants and helper functions for the grid DFS explore controller.
// Used by gdfs_nbr, gdfs_act_buf and the controller unit; depends on nothing else.
package gdfs_pkg;

    // Grid and stack sizing.
    localparam int GRID_BITS   = 6;
    localparam int STACK_DEPTH = 4096;
    localparam int GRID_SIZE   = 1 << GRID_BITS;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_W     = 5;
    localparam int CFG_W       = 6;

    // Action buffer sizing: one run holds at most five actions.
    localparam int ACT_SLOTS = 5;
    localparam int CNT_W     = $clog2(ACT_SLOTS + 1);
    localparam int SLOT_W    = $clog2(ACT_SLOTS);

    typedef logic [GRID_BITS-1:0] t_coord;
    typedef logic [LEVEL_W-1:0]   t_level;
    typedef logic [GRID_SIZE-1:0] t_row;
    typedef logic [1:0]           t_dir;
    typedef logic [1:0]           t_act;
    typedef logic [1:0]           t_phase;

    // Directions.
    localparam t_dir DIR_UP    = 2'd0;
    localparam t_dir DIR_DOWN  = 2'd1;
    localparam t_dir DIR_LEFT  = 2'd2;
    localparam t_dir DIR_RIGHT = 2'd3;

    // Action codes.
    localparam t_act ACT_CLEAN = 2'd0;
    localparam t_act ACT_LEFT  = 2'd1;
    localparam t_act ACT_RIGHT = 2'd2;
    localparam t_act ACT_MOVE  = 2'd3;

    // Exploration phases.
    localparam t_phase PH_IDLE    = 2'd0;
    localparam t_phase PH_EXPLORE = 2'd1;
    localparam t_phase PH_RETURN  = 2'd2;
    localparam t_phase PH_DONE    = 2'd3;

    // Input commands.
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_START_ROW = 1'b0;
    localparam logic CFG_START_COL = 1'b1;

    // Neighbour index value that marks an entry with all neighbours tried.
    localparam logic [2:0] IDX_DONE = 3'd4;

    // Turns needed to align the heading: n copies of act.
    typedef struct packed {
        logic [1:0] n;
        t_act       act;
    } t_turn;

    // Actions produced in one cycle, in the order clean, turns, move.
    typedef struct packed {
        logic  clean;
        t_turn turn;
        logic  move;
    } t_emit;

    // Neighbour cell and whether it lies inside the grid.
    typedef struct packed {
        logic   valid;
        t_coord row;
        t_coord col;
    } t_nbr;

    // Heading reached by one right turn.
    function automatic t_dir clockwise(input t_dir d);
        t_dir r;
        unique case (d)
            DIR_UP:    r = DIR_RIGHT;
            DIR_DOWN:  r = DIR_LEFT;
            DIR_LEFT:  r = DIR_UP;
            default:   r = DIR_DOWN;
        endcase
        return r;
    endfunction

    // Turns that bring heading cur to need; a reversal is two rights.
    function automatic t_turn align_turn(input t_dir cur, input t_dir need);
        t_turn t;
        t.n   = 2'd0;
        t.act = ACT_RIGHT;
        if (cur == need) begin
            t.n = 2'd0;
        end else if ((cur ^ 2'd1) == need) begin
            t.n = 2'd2;
        end else if (clockwise(cur) == need) begin
            t.n = 2'd1;
        end else begin
            t.n   = 2'd1;
            t.act = ACT_LEFT;
        end
        return t;
    endfunction

endpackage

// ----- hw/rtl/gdfs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the visited map and the path stack.
module gdfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/gdfs_nbr.sv -----
// Shared neighbour unit: steps one cell from a position in a direction and flags grid edges.
// Depends on gdfs_pkg.
module gdfs_nbr (
    input  gdfs_pkg::t_coord i_row,
    input  gdfs_pkg::t_coord i_col,
    input  gdfs_pkg::t_dir   i_dir,
    output gdfs_pkg::t_nbr   o_nbr
);

    // One step in the chosen direction; a step off the grid is invalid.
    always_comb begin
        o_nbr.valid = 1'b1;
        o_nbr.row   = i_row;
        o_nbr.col   = i_col;
        unique case (i_dir)
            gdfs_pkg::DIR_UP: begin
                o_nbr.valid = (i_row != '0);
                o_nbr.row   = i_row - gdfs_pkg::t_coord'(1);
            end
            gdfs_pkg::DIR_DOWN: begin
                o_nbr.valid = (i_row != '1);
                o_nbr.row   = i_row + gdfs_pkg::t_coord'(1);
            end
            gdfs_pkg::DIR_LEFT: begin
                o_nbr.valid = (i_col != '0);
                o_nbr.col   = i_col - gdfs_pkg::t_coord'(1);
            end
            default: begin
                o_nbr.valid = (i_col != '1);
                o_nbr.col   = i_col + gdfs_pkg::t_coord'(1);
            end
        endcase
    end

endmodule

// ----- hw/rtl/gdfs_act_buf.sv -----
// Action buffer: collects the actions of one run, then streams them out with last and finished.
// Depends on gdfs_pkg.
module gdfs_act_buf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gdfs_pkg::t_emit       i_emit,
    input  logic                  i_go,
    input  logic                  i_fin,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output gdfs_pkg::t_act        o_action,
    output logic                  o_last,
    output logic                  o_fin,
    output logic                  o_busy
);

    gdfs_pkg::t_act                 r_act [gdfs_pkg::ACT_SLOTS];
    gdfs_pkg::t_act                 n_act [gdfs_pkg::ACT_SLOTS];
    logic [gdfs_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [gdfs_pkg::SLOT_W-1:0]    r_rd, n_rd;
    logic                           r_drain, n_drain;
    logic                           r_fin, n_fin;
    logic                           w_last;
    logic                           w_take;

    assign w_last = (gdfs_pkg::CNT_W'(r_rd) == (r_cnt - gdfs_pkg::CNT_W'(1)));
    assign w_take = r_drain && i_m_tready;

    // Append new actions behind the stored ones and step the read pointer on each accepted transfer.
    always_comb begin
        int m;
        int off;
        int c;
        int nt;
        int sum;
        c   = int'(i_emit.clean);
        nt  = int'(i_emit.turn.n);
        m   = c + nt + int'(i_emit.move);
        off = 0;
        sum = int'(r_cnt) + m;
        for (int k = 0; k < gdfs_pkg::ACT_SLOTS; k++) begin
            n_act[k] = r_act[k];
            if (k >= int'(r_cnt) && k < sum) begin
                off = k - int'(r_cnt);
                if (off < c) begin
                    n_act[k] = gdfs_pkg::ACT_CLEAN;
                end else if (off < c + nt) begin
                    n_act[k] = i_emit.turn.act;
                end else begin
                    n_act[k] = gdfs_pkg::ACT_MOVE;
                end
            end
        end
        n_cnt   = r_cnt;
        n_rd    = r_rd;
        n_drain = r_drain;
        n_fin   = r_fin;
        if (w_take) begin
            if (w_last) begin
                n_cnt   = '0;
                n_rd    = '0;
                n_drain = 1'b0;
            end else begin
                n_rd = r_rd + gdfs_pkg::SLOT_W'(1);
            end
        end else if (i_go) begin
            n_drain = (r_cnt != '0);
            n_fin   = i_fin;
        end else if (m != 0) begin
            n_cnt = (sum > gdfs_pkg::ACT_SLOTS) ? gdfs_pkg::CNT_W'(gdfs_pkg::ACT_SLOTS)
                                                : gdfs_pkg::CNT_W'(sum);
        end
    end

    // Control state resets; stored actions and the finished flag are payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_rd    <= '0;
            r_drain <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_rd    <= n_rd;
            r_drain <= n_drain;
        end
        r_fin <= n_fin;
        for (int k = 0; k < gdfs_pkg::ACT_SLOTS; k++) begin
            r_act[k] <= n_act[k];
        end
    end

    assign o_m_tvalid = r_drain;
    assign o_action   = r_act[r_rd];
    assign o_last     = w_last;
    assign o_fin      = r_fin;
    assign o_busy     = r_drain || (r_cnt != '0);

endmodule

// ----- hw/rtl/grid_dfs_explore_controller_unit.sv -----
// Grid DFS explore controller: sequencer, position/stack state, RAMs and the output stream.
// Depends on gdfs_pkg, gdfs_ram, gdfs_nbr and gdfs_act_buf.
// A report is sequenced one neighbour at a time through the shared neighbour unit and the
// visited-row read port; its actions are then streamed out from the action buffer.
// A start item first sweeps the visited map one row per cycle, all GRID_SIZE = 64 rows.
// One item is handled at a time; the input is ready again once the last action is taken.
// Reset is synchronous, active low; the visited map is swept on every start, the stack is not.
module grid_dfs_explore_controller_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input stream: tuser = cmd; tdata bit 0 = moved, bits 7:1 zero.
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [7:0]                 i_s_tdata,
    input  logic                       i_s_tuser,
    // Output stream: tdata bits 1:0 = action, bits 7:2 zero; tlast = last_in_run.
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [7:0]                 o_m_tdata,
    output logic                       o_m_tlast,
    // tuser = finished.
    output logic                       o_m_tuser,
    // Configuration write channel.
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [gdfs_pkg::CFG_W-1:0] i_cfg_data
);

    // Sequencer state codes.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_PUSH  = 3'd2;
    localparam logic [2:0] ST_MARK  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_CHECK = 3'd5;
    localparam logic [2:0] ST_POP   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0]                  r_state, n_state;
    gdfs_pkg::t_coord            r_sweep, n_sweep;
    gdfs_pkg::t_coord            r_pos_row, n_pos_row;
    gdfs_pkg::t_coord            r_pos_col, n_pos_col;
    gdfs_pkg::t_dir              r_heading, n_heading;
    gdfs_pkg::t_phase            r_phase, n_phase;
    gdfs_pkg::t_level            r_level, n_level;
    gdfs_pkg::t_dir              r_top_arr, n_top_arr;
    logic [2:0]                  r_top_idx, n_top_idx;
    gdfs_pkg::t_dir              r_push_arr, n_push_arr;
    logic                        r_fin, n_fin;
    logic [gdfs_pkg::CFG_W-1:0]  r_start_row, n_start_row;
    logic [gdfs_pkg::CFG_W-1:0]  r_start_col, n_start_col;

    logic                           w_in_acc;
    logic                           w_room;
    logic                           w_buf_busy;
    gdfs_pkg::t_dir                 w_dir;
    gdfs_pkg::t_nbr                 w_nbr;
    gdfs_pkg::t_emit                w_emit;
    logic                           w_go;
    gdfs_pkg::t_act                 w_action;

    logic                           w_v_we;
    gdfs_pkg::t_coord               w_v_waddr;
    gdfs_pkg::t_row                 w_v_wdata;
    gdfs_pkg::t_coord               w_v_raddr;
    gdfs_pkg::t_row                 w_v_rdata;

    logic                           w_s_we;
    logic [gdfs_pkg::STACK_AW-1:0]  w_s_waddr;
    logic [gdfs_pkg::ENTRY_W-1:0]   w_s_wdata;
    logic [gdfs_pkg::STACK_AW-1:0]  w_s_raddr;
    logic [gdfs_pkg::ENTRY_W-1:0]   w_s_rdata;
    logic [gdfs_pkg::STACK_AW-1:0]  w_top_addr;

    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == ST_IDLE) && !w_buf_busy;
    assign o_cfg_ready = 1'b1;
    assign w_room     = (r_level < gdfs_pkg::LEVEL_W'(gdfs_pkg::STACK_DEPTH));
    assign w_top_addr = gdfs_pkg::STACK_AW'(r_level - gdfs_pkg::LEVEL_W'(1));
    // The entry below the top, read while backtracking and captured in the pop step.
    assign w_s_raddr  = gdfs_pkg::STACK_AW'(r_level - gdfs_pkg::LEVEL_W'(2));

    // Direction fed to the shared neighbour unit in each step.
    always_comb begin
        if (r_state == ST_IDLE) begin
            w_dir = r_top_idx[1:0] - 2'd1;
        end else if (r_state == ST_SCAN && r_top_idx[2]) begin
            w_dir = r_top_arr ^ 2'd1;
        end else begin
            w_dir = r_top_idx[1:0];
        end
    end

    gdfs_nbr u_nbr (
        .i_row (r_pos_row),
        .i_col (r_pos_col),
        .i_dir (w_dir),
        .o_nbr (w_nbr)
    );

    // Visited map: one row of cells per word.
    gdfs_ram #(
        .WIDTH (gdfs_pkg::GRID_SIZE),
        .DEPTH (gdfs_pkg::GRID_SIZE)
    ) u_visited (
        .i_clk   (i_clk),
        .i_we    (w_v_we),
        .i_waddr (w_v_waddr),
        .i_wdata (w_v_wdata),
        .i_raddr (w_v_raddr),
        .o_rdata (w_v_rdata)
    );

    // Path stack: arrival direction in bits 1:0, next neighbour in bits 4:2.
    gdfs_ram #(
        .WIDTH (gdfs_pkg::ENTRY_W),
        .DEPTH (gdfs_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_s_we),
        .i_waddr (w_s_waddr),
        .i_wdata (w_s_wdata),
        .i_raddr (w_s_raddr),
        .o_rdata (w_s_rdata)
    );

    // Sequencer: start sweep, push, neighbour scan and backtrack.
    always_comb begin
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_pos_row   = r_pos_row;
        n_pos_col   = r_pos_col;
        n_heading   = r_heading;
        n_phase     = r_phase;
        n_level     = r_level;
        n_top_arr   = r_top_arr;
        n_top_idx   = r_top_idx;
        n_push_arr  = r_push_arr;
        n_fin       = r_fin;
        n_start_row = r_start_row;
        n_start_col = r_start_col;
        w_emit      = '0;
        w_go        = 1'b0;
        w_v_we      = 1'b0;
        w_v_waddr   = r_pos_row;
        w_v_wdata   = '0;
        w_v_raddr   = w_nbr.row;
        w_s_we      = 1'b0;
        w_s_waddr   = w_top_addr;
        w_s_wdata   = '0;

        // Configuration writes.
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gdfs_pkg::CFG_START_ROW: n_start_row = i_cfg_data;
                default:                 n_start_col = i_cfg_data;
            endcase
        end

        if (w_in_acc) begin
            n_fin = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_s_tuser == gdfs_pkg::CMD_START) begin
                        n_sweep = '0;
                        n_phase = gdfs_pkg::PH_IDLE;
                        n_state = ST_CLEAR;
                    end else if (r_level == '0) begin
                        if (r_phase != gdfs_pkg::PH_DONE) begin
                            n_phase = gdfs_pkg::PH_IDLE;
                        end
                    end else if (r_phase == gdfs_pkg::PH_EXPLORE) begin
                        if (i_s_tdata[0] && w_room && w_nbr.valid) begin
                            n_pos_row  = w_nbr.row;
                            n_pos_col  = w_nbr.col;
                            n_push_arr = w_dir;
                            n_state    = ST_PUSH;
                        end else begin
                            w_emit.turn = gdfs_pkg::align_turn(r_heading, r_top_arr);
                            n_heading   = r_top_arr;
                            n_state     = ST_SCAN;
                        end
                    end else if (r_phase == gdfs_pkg::PH_RETURN) begin
                        w_emit.turn = gdfs_pkg::align_turn(r_heading, r_top_arr);
                        n_heading   = r_top_arr;
                        n_state     = ST_SCAN;
                    end
                end
            end
            ST_CLEAR: begin
                // Clear one visited row per cycle, then place the robot at the start cell.
                w_v_we    = 1'b1;
                w_v_waddr = r_sweep;
                n_sweep   = r_sweep + gdfs_pkg::t_coord'(1);
                if (r_sweep == '1) begin
                    n_pos_row  = gdfs_pkg::t_coord'(r_start_row);
                    n_pos_col  = gdfs_pkg::t_coord'(r_start_col);
                    n_heading  = gdfs_pkg::DIR_UP;
                    n_level    = '0;
                    n_push_arr = gdfs_pkg::DIR_UP;
                    n_state    = ST_PUSH;
                end
            end
            ST_PUSH: begin
                // Open a new top entry and fetch the current row for marking.
                if (w_room) begin
                    w_s_we    = 1'b1;
                    w_s_waddr = r_level[gdfs_pkg::STACK_AW-1:0];
                    w_s_wdata = {3'd0, r_push_arr};
                    n_level   = r_level + gdfs_pkg::LEVEL_W'(1);
                    n_top_arr = r_push_arr;
                    n_top_idx = '0;
                end
                w_v_raddr = r_pos_row;
                n_state   = ST_MARK;
            end
            ST_MARK: begin
                w_v_we       = 1'b1;
                w_v_waddr    = r_pos_row;
                w_v_wdata    = w_v_rdata | (gdfs_pkg::t_row'(1) << r_pos_col);
                w_emit.clean = 1'b1;
                n_state      = ST_SCAN;
            end
            ST_SCAN: begin
                if (!r_top_idx[2]) begin
                    // Skip neighbours off the grid or when the stack is full.
                    if (w_room && w_nbr.valid) begin
                        n_state = ST_CHECK;
                    end else begin
                        n_top_idx = r_top_idx + 3'd1;
                    end
                end else begin
                    // All neighbours tried: turn back and leave the cell.
                    n_top_idx   = gdfs_pkg::IDX_DONE;
                    w_s_we      = 1'b1;
                    w_s_wdata   = {gdfs_pkg::IDX_DONE, r_top_arr};
                    w_emit.turn = gdfs_pkg::align_turn(r_heading, r_top_arr ^ 2'd1);
                    w_emit.move = 1'b1;
                    n_heading   = r_top_arr ^ 2'd1;
                    if (r_level <= gdfs_pkg::LEVEL_W'(1)) begin
                        n_phase = gdfs_pkg::PH_DONE;
                        n_fin   = 1'b1;
                        n_state = ST_OUT;
                    end else begin
                        n_level = r_level - gdfs_pkg::LEVEL_W'(1);
                        if (w_nbr.valid) begin
                            n_pos_row = w_nbr.row;
                            n_pos_col = w_nbr.col;
                        end
                        n_phase = gdfs_pkg::PH_RETURN;
                        n_state = ST_POP;
                    end
                end
            end
            ST_CHECK: begin
                if (!w_v_rdata[w_nbr.col]) begin
                    // Unvisited neighbour: face it and move.
                    w_emit.turn = gdfs_pkg::align_turn(r_heading, r_top_idx[1:0]);
                    w_emit.move = 1'b1;
                    n_heading   = r_top_idx[1:0];
                    n_top_idx   = r_top_idx + 3'd1;
                    w_s_we      = 1'b1;
                    w_s_wdata   = {r_top_idx + 3'd1, r_top_arr};
                    n_phase     = gdfs_pkg::PH_EXPLORE;
                    n_state     = ST_OUT;
                end else begin
                    n_top_idx = r_top_idx + 3'd1;
                    n_state   = ST_SCAN;
                end
            end
            ST_POP: begin
                n_top_arr = w_s_rdata[1:0];
                n_top_idx = w_s_rdata[4:2];
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                w_go    = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and configuration registers reset; scan scratch registers are payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos_row   <= '0;
            r_pos_col   <= '0;
            r_heading   <= gdfs_pkg::DIR_UP;
            r_phase     <= gdfs_pkg::PH_IDLE;
            r_level     <= '0;
            r_fin       <= 1'b0;
            r_start_row <= gdfs_pkg::CFG_W'(32);
            r_start_col <= gdfs_pkg::CFG_W'(32);
        end else begin
            r_state     <= n_state;
            r_pos_row   <= n_pos_row;
            r_pos_col   <= n_pos_col;
            r_heading   <= n_heading;
            r_phase     <= n_phase;
            r_level     <= n_level;
            r_fin       <= n_fin;
            r_start_row <= n_start_row;
            r_start_col <= n_start_col;
        end
        r_sweep    <= n_sweep;
        r_top_arr  <= n_top_arr;
        r_top_idx  <= n_top_idx;
        r_push_arr <= n_push_arr;
    end

    gdfs_act_buf u_act_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_emit     (w_emit),
        .i_go       (w_go),
        .i_fin      (r_fin),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_action   (w_action),
        .o_last     (o_m_tlast),
        .o_fin      (o_m_tuser),
        .o_busy     (w_buf_busy)
    );

    assign o_m_tdata = {6'd0, w_action};

`ifndef SYNTHESIS
    // The stack level never passes the stack depth.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= gdfs_pkg::LEVEL_W'(gdfs_pkg::STACK_DEPTH))
        else $error("stack level beyond depth");

    // A start request always begins with the visited-map sweep.
    a_start_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_s_tuser == gdfs_pkg::CMD_START) |=> (r_state == ST_CLEAR))
        else $error("start request did not enter the sweep");

    // Actions are streamed only while the sequencer is parked.
    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_state == ST_IDLE))
        else $error("output active while sequencer busy");

    // A finished exploration leaves only the root entry on the stack.
    a_done_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == gdfs_pkg::PH_DONE) |-> (r_level == gdfs_pkg::LEVEL_W'(1)))
        else $error("finished with stack level other than one");
`endif

endmodule
